// ===== hdl/bgs_pkg.sv =====
// Shared types and constants for the battery gauge smoother.
// No dependencies; every other file in hdl/ imports this package.
package bgs_pkg;

   localparam int MV_W      = 15;
   localparam int PCT_W     = 7;
   localparam int CSR_IDX_W = 4;

   // millivolt conversion: mv = floor(((raw + 35) * 400 + 43) / 86)
   localparam int MV_OFFSET = 35;
   localparam int MV_ROUND  = 43;
   localparam longint unsigned MV_DIVISOR = 86;

   // average: floor((9 * avg + mv + 5) / 10)
   localparam int AVG_NUM_W = 19;
   localparam int AVG_ROUND = 5;
   localparam longint unsigned AVG_DIVISOR = 10;

   // quadratic estimate, coefficients scaled by 1e11
   localparam int MUL_A_W = 39;
   localparam int PROD_W  = MUL_A_W + MV_W;
   localparam longint unsigned PCT_SCALE = 64'd100000000000;
   localparam int PCT_STEPS = PCT_W;
   localparam int PCT_REM_W = $clog2(PCT_SCALE);
   localparam int U_W       = PCT_REM_W + PCT_STEPS;

   localparam logic signed [MUL_A_W-1:0] COEF_SQ   = 39'sd7847975;
   localparam logic signed [MUL_A_W-1:0] COEF_LIN  = 39'sd204973100000;
   localparam logic signed [PROD_W-1:0]  COEF_OFS  = 54'sd1327504000000000;
   // P at or above this rounds to more than 100 percent
   localparam logic signed [PROD_W-1:0]  SAT_LEVEL = 54'sd10050000000000;
   localparam logic [U_W-1:0]            HALF_SCALE = 44'd50000000000;

   localparam logic [MV_W-1:0]  MV_MAX       = 15'h7FFF;
   localparam logic [MV_W-1:0]  CHG_THR_RST  = 15'd13200;
   localparam logic [MV_W-1:0]  DEAD_THR_RST = 15'd11883;
   localparam logic [PCT_W-1:0] PCT_FULL     = 7'd100;
   localparam logic [PCT_W-1:0] PCT_EMPTY    = 7'd0;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CHG_THR  = 4'd0,
      CSR_DEAD_THR = 4'd1
   } csr_idx_type;

   typedef struct packed {
      logic busy;
      logic done;
   } unit_stat_type;

endpackage

// ===== hdl/bgs_if.sv =====
// Channel interfaces of the battery gauge smoother: sample, result, register write.
// Depends on bgs_pkg.
interface bgs_req_if #(parameter int SAMPLE_BITS = 12);
   logic                   valid;
   logic                   ready;
   logic [SAMPLE_BITS-1:0] raw_sample;

   modport source (output valid, output raw_sample, input ready);
   modport sink   (input valid, input raw_sample, output ready);
endinterface

interface bgs_rsp_if;
   import bgs_pkg::*;
   logic             valid;
   logic             ready;
   logic [MV_W-1:0]  smoothed_mv;
   logic [PCT_W-1:0] charge_percent;
   logic             charging;
   logic             dead;

   modport source (output valid, output smoothed_mv, output charge_percent,
                   output charging, output dead, input ready);
   modport sink   (input valid, input smoothed_mv, input charge_percent,
                   input charging, input dead, output ready);
endinterface

interface bgs_csr_if;
   import bgs_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [MV_W-1:0]      data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hdl/bgs_cdiv.sv =====
// Bit-serial restoring divider by a constant, one quotient bit per cycle.
// Depends on bgs_pkg (status struct).
module bgs_cdiv #(
   parameter longint unsigned DIVISOR = 10,
   parameter int STEPS = 19,
   localparam int REM_W = $clog2(DIVISOR),
   localparam int CNT_W = $clog2(STEPS + 1)
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [REM_W-1:0]       rem_init,
   input  logic [STEPS-1:0]       num_init,
   output bgs_pkg::unit_stat_type stat,
   output logic [STEPS-1:0]       quotient
);
   import bgs_pkg::*;

   localparam logic [REM_W:0] DIV_C = (REM_W + 1)'(DIVISOR);

   logic [REM_W-1:0] rem_ff, rem_in;
   logic [STEPS-1:0] num_ff, num_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             done_ff, done_in;
   logic [REM_W:0]   trial, diff;
   logic             ge;

   always_comb begin
      trial   = {rem_ff, num_ff[STEPS-1]};
      diff    = trial - DIV_C;
      ge      = (trial >= DIV_C);
      rem_in  = rem_ff;
      num_in  = num_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in = rem_init;
         num_in = num_init;
         cnt_in = CNT_W'(STEPS);
      end else if (cnt_ff != '0) begin
         rem_in  = ge ? diff[REM_W-1:0] : trial[REM_W-1:0];
         num_in  = {num_ff[STEPS-2:0], ge};
         cnt_in  = cnt_ff - 1'b1;
         done_in = (cnt_ff == CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      num_ff <= num_in;
   end

   assign stat.busy = (cnt_ff != '0);
   assign stat.done = done_ff;
   assign quotient  = num_ff;

endmodule

// ===== hdl/bgs_smul.sv =====
// Serial shift-add multiplier: signed multiplicand times unsigned multiplier,
// one multiplier bit per cycle. Depends on bgs_pkg (status struct).
module bgs_smul #(
   parameter int A_W = 39,
   parameter int B_W = 15,
   localparam int P_W   = A_W + B_W,
   localparam int CNT_W = $clog2(B_W + 1)
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic signed [A_W-1:0]  a_in,
   input  logic [B_W-1:0]         b_in,
   output bgs_pkg::unit_stat_type stat,
   output logic signed [P_W-1:0]  product
);
   import bgs_pkg::*;

   logic signed [A_W-1:0] a_ff, a_in_mux;
   logic [A_W-1:0]        hi_ff, hi_in;
   logic [B_W-1:0]        lo_ff, lo_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic                  done_ff, done_in;
   logic [A_W:0]          sum;

   always_comb begin
      sum      = {hi_ff[A_W-1], hi_ff} + (lo_ff[0] ? {a_ff[A_W-1], a_ff} : '0);
      a_in_mux = a_ff;
      hi_in    = hi_ff;
      lo_in    = lo_ff;
      cnt_in   = cnt_ff;
      done_in  = 1'b0;
      if (start) begin
         a_in_mux = a_in;
         hi_in    = '0;
         lo_in    = b_in;
         cnt_in   = CNT_W'(B_W);
      end else if (cnt_ff != '0) begin
         // add partial product, then arithmetic shift of {hi, lo}
         hi_in   = sum[A_W:1];
         lo_in   = {sum[0], lo_ff[B_W-1:1]};
         cnt_in  = cnt_ff - 1'b1;
         done_in = (cnt_ff == CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff  <= a_in_mux;
      hi_ff <= hi_in;
      lo_ff <= lo_in;
   end

   assign stat.busy = (cnt_ff != '0);
   assign stat.done = done_ff;
   assign product   = $signed({hi_ff, lo_ff});

endmodule

// ===== hdl/battery_gauge_smoother_core.sv =====
// Battery gauge smoother top level: sequencer, register file and output stage.
// Depends on bgs_pkg, bgs_if, bgs_cdiv and bgs_smul.
//
// Usage:
//  - req_bus carries one converter sample (raw_sample) per item. Ready is high
//    only while the sequencer is idle; one item is worked on at a time.
//  - rsp_bus returns one item per sample: smoothed_mv, charge_percent,
//    charging and dead.
//  - csr_bus writes register 0 (charging threshold) or 1 (dead threshold);
//    always ready, other indexes are dropped. Write only while idle.
//  - Processing time is set by the serial divide by 86 (SAMPLE_BITS+9 bits),
//    the divide by 10 (19 bits), two 15-bit serial multiplies and a 7-bit
//    divide, all one bit per cycle. The first sample skips the divide by 10;
//    a result set by a threshold skips the multiplies and the 7-bit divide.
//  - A new sample is accepted the cycle after the result is loaded into the
//    output register, even if the receiver has not taken it yet. If the
//    receiver still stalls when the next result is done, the sequencer waits.
//  - Reset clears the average (next sample loads it directly), restores the
//    threshold reset values and empties the output register.
module battery_gauge_smoother_core #(
   parameter int SAMPLE_BITS = 12
) (
   input  logic       clock,
   input  logic       reset,
   bgs_req_if.sink    req_bus,
   bgs_rsp_if.source  rsp_bus,
   bgs_csr_if.sink    csr_bus
);
   import bgs_pkg::*;

   // numerator of the millivolt conversion, (raw+35)*400+43
   localparam int NUM_W = SAMPLE_BITS + 9;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DIV_MV,
      S_DIV_AVG,
      S_CLASSIFY,
      S_MUL_SQ,
      S_MUL_LIN,
      S_ROUND,
      S_DIV_PCT,
      S_DONE
   } state_type;

   state_type state_ff;

   // registers
   logic [MV_W-1:0] chg_thr_ff, dead_thr_ff;
   logic [MV_W-1:0] avg_ff;
   logic            avg_valid_ff;

   // unit controls
   logic                      div_mv_start_ff;
   logic [NUM_W-1:0]          div_mv_num_ff;
   logic                      div_avg_start_ff;
   logic [AVG_NUM_W-1:0]      div_avg_num_ff;
   logic                      mul_start_ff;
   logic signed [MUL_A_W-1:0] mul_a_ff;
   logic                      div_pct_start_ff;
   logic [PCT_REM_W-1:0]      div_pct_rem_ff;
   logic [PCT_STEPS-1:0]      div_pct_num_ff;
   logic signed [PROD_W-1:0]  p_ff;

   // pending result and output register
   logic [PCT_W-1:0] pct_ff;
   logic             chg_ff, dead_ff;
   logic             rsp_valid_ff;
   logic [MV_W-1:0]  rsp_mv_ff;
   logic [PCT_W-1:0] rsp_pct_ff;
   logic             rsp_chg_ff, rsp_dead_ff;

   // unit outputs
   unit_stat_type            div_mv_stat, div_avg_stat, mul_stat, div_pct_stat;
   logic [NUM_W-1:0]         div_mv_q;
   logic [AVG_NUM_W-1:0]     div_avg_q;
   logic [PCT_STEPS-1:0]     div_pct_q;
   logic signed [PROD_W-1:0] mul_prod;

   // combinational helpers
   logic [NUM_W-1:0]          s35, num_calc;
   logic [MV_W-1:0]           mv_sat;
   logic [AVG_NUM_W-1:0]      avg_num;
   logic signed [MUL_A_W-1:0] t_calc;
   logic signed [PROD_W-1:0]  p_calc;
   logic [U_W-1:0]            u_calc;
   logic                      is_dead, is_chg, p_nonpos;
   logic                      req_take;
   logic                      rsp_load;

   assign req_take = req_bus.valid && req_bus.ready;
   // output slot free, or being emptied this cycle
   assign rsp_load = (state_ff == S_DONE) && (!rsp_valid_ff || rsp_bus.ready);

   always_comb begin
      s35      = NUM_W'(req_bus.raw_sample) + NUM_W'(MV_OFFSET);
      // *400 as *256 + *128 + *16
      num_calc = (s35 << 8) + (s35 << 7) + (s35 << 4) + NUM_W'(MV_ROUND);
      mv_sat   = (|div_mv_q[NUM_W-1:MV_W]) ? MV_MAX : div_mv_q[MV_W-1:0];
      avg_num  = (AVG_NUM_W'(avg_ff) << 3) + AVG_NUM_W'(avg_ff)
                 + AVG_NUM_W'(mv_sat) + AVG_NUM_W'(AVG_ROUND);
      // first product is positive and below 2^38
      t_calc   = COEF_LIN - $signed(mul_prod[MUL_A_W-1:0]);
      p_calc   = mul_prod - COEF_OFS;
      // used only for 0 < P < SAT_LEVEL, so P fits in U_W bits
      u_calc   = p_ff[U_W-1:0] + HALF_SCALE;
      p_nonpos = p_ff[PROD_W-1] || (p_ff == '0);
      is_dead  = (avg_ff < dead_thr_ff);
      is_chg   = (avg_ff > chg_thr_ff);
   end

   bgs_cdiv #(.DIVISOR(MV_DIVISOR), .STEPS(NUM_W)) u_div_mv (
      .clock    (clock),
      .reset    (reset),
      .start    (div_mv_start_ff),
      .rem_init ('0),
      .num_init (div_mv_num_ff),
      .stat     (div_mv_stat),
      .quotient (div_mv_q)
   );

   bgs_cdiv #(.DIVISOR(AVG_DIVISOR), .STEPS(AVG_NUM_W)) u_div_avg (
      .clock    (clock),
      .reset    (reset),
      .start    (div_avg_start_ff),
      .rem_init ('0),
      .num_init (div_avg_num_ff),
      .stat     (div_avg_stat),
      .quotient (div_avg_q)
   );

   // shared by v*COEF_SQ and v*(COEF_LIN - v*COEF_SQ)
   bgs_smul #(.A_W(MUL_A_W), .B_W(MV_W)) u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start_ff),
      .a_in    (mul_a_ff),
      .b_in    (avg_ff),
      .stat    (mul_stat),
      .product (mul_prod)
   );

   // upper bits of the rounded estimate preload the remainder (< 1e11),
   // leaving 7 quotient bits
   bgs_cdiv #(.DIVISOR(PCT_SCALE), .STEPS(PCT_STEPS)) u_div_pct (
      .clock    (clock),
      .reset    (reset),
      .start    (div_pct_start_ff),
      .rem_init (div_pct_rem_ff),
      .num_init (div_pct_num_ff),
      .stat     (div_pct_stat),
      .quotient (div_pct_q)
   );

   // register writes
   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         chg_thr_ff  <= CHG_THR_RST;
         dead_thr_ff <= DEAD_THR_RST;
      end else if (csr_bus.valid) begin
         case (csr_bus.index)
            CSR_CHG_THR:  chg_thr_ff  <= csr_bus.data;
            CSR_DEAD_THR: dead_thr_ff <= csr_bus.data;
            default: ;
         endcase
      end
   end

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= S_IDLE;
         avg_valid_ff     <= 1'b0;
         avg_ff           <= '0;
         div_mv_start_ff  <= 1'b0;
         div_avg_start_ff <= 1'b0;
         mul_start_ff     <= 1'b0;
         div_pct_start_ff <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         // one-cycle start strobes for the arithmetic units
         div_mv_start_ff  <= (state_ff == S_IDLE) && req_take;
         div_avg_start_ff <= (state_ff == S_DIV_MV) && div_mv_stat.done && avg_valid_ff;
         mul_start_ff     <= ((state_ff == S_CLASSIFY) && !is_dead && !is_chg)
                             || ((state_ff == S_MUL_SQ) && mul_stat.done);
         div_pct_start_ff <= (state_ff == S_ROUND) && !p_nonpos && (p_ff < SAT_LEVEL);
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_bus.valid && rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_take) begin
                  div_mv_num_ff <= num_calc;
                  state_ff      <= S_DIV_MV;
               end
            end
            S_DIV_MV: begin
               if (div_mv_stat.done) begin
                  if (avg_valid_ff) begin
                     div_avg_num_ff <= avg_num;
                     state_ff       <= S_DIV_AVG;
                  end else begin
                     // first sample loads the average
                     avg_ff       <= mv_sat;
                     avg_valid_ff <= 1'b1;
                     state_ff     <= S_CLASSIFY;
                  end
               end
            end
            S_DIV_AVG: begin
               if (div_avg_stat.done) begin
                  avg_ff   <= div_avg_q[MV_W-1:0];
                  state_ff <= S_CLASSIFY;
               end
            end
            S_CLASSIFY: begin
               chg_ff  <= is_chg;
               dead_ff <= is_dead;
               // dead wins over charging
               if (is_dead) begin
                  pct_ff   <= PCT_EMPTY;
                  state_ff <= S_DONE;
               end else if (is_chg) begin
                  pct_ff   <= PCT_FULL;
                  state_ff <= S_DONE;
               end else begin
                  mul_a_ff <= COEF_SQ;
                  state_ff <= S_MUL_SQ;
               end
            end
            S_MUL_SQ: begin
               if (mul_stat.done) begin
                  mul_a_ff <= t_calc;
                  state_ff <= S_MUL_LIN;
               end
            end
            S_MUL_LIN: begin
               if (mul_stat.done) begin
                  p_ff     <= p_calc;
                  state_ff <= S_ROUND;
               end
            end
            S_ROUND: begin
               if (p_nonpos) begin
                  pct_ff   <= PCT_EMPTY;
                  state_ff <= S_DONE;
               end else if (p_ff >= SAT_LEVEL) begin
                  pct_ff   <= PCT_FULL;
                  state_ff <= S_DONE;
               end else begin
                  div_pct_rem_ff <= u_calc[U_W-1:PCT_STEPS];
                  div_pct_num_ff <= u_calc[PCT_STEPS-1:0];
                  state_ff       <= S_DIV_PCT;
               end
            end
            S_DIV_PCT: begin
               if (div_pct_stat.done) begin
                  pct_ff   <= div_pct_q;
                  state_ff <= S_DONE;
               end
            end
            S_DONE: begin
               if (rsp_load) begin
                  rsp_mv_ff   <= avg_ff;
                  rsp_pct_ff  <= pct_ff;
                  rsp_chg_ff  <= chg_ff;
                  rsp_dead_ff <= dead_ff;
                  state_ff    <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_bus.ready          = (state_ff == S_IDLE);
   assign rsp_bus.valid          = rsp_valid_ff;
   assign rsp_bus.smoothed_mv    = rsp_mv_ff;
   assign rsp_bus.charge_percent = rsp_pct_ff;
   assign rsp_bus.charging       = rsp_chg_ff;
   assign rsp_bus.dead           = rsp_dead_ff;

   // checks
   a_units_idle_when_ready: assert property (@(posedge clock) disable iff (reset)
      req_bus.ready |-> !(div_mv_stat.busy || div_avg_stat.busy || mul_stat.busy ||
                          div_pct_stat.busy))
      else $error("arithmetic unit busy while taking a new item");

   a_one_unit_busy: assert property (@(posedge clock) disable iff (reset)
      $onehot0({div_mv_stat.busy, div_avg_stat.busy, mul_stat.busy, div_pct_stat.busy}))
      else $error("more than one arithmetic unit running");

   a_pct_range: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid |-> (rsp_bus.charge_percent <= PCT_FULL))
      else $error("charge percent above full");

   a_dead_empty: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && rsp_bus.dead) |-> (rsp_bus.charge_percent == PCT_EMPTY))
      else $error("dead battery reports nonzero charge");

   a_chg_full: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && rsp_bus.charging && !rsp_bus.dead)
         |-> (rsp_bus.charge_percent == PCT_FULL))
      else $error("charging battery not reported full");

endmodule

// ===== test/testbench.sv =====
// Testbench for battery_gauge_smoother_core: sample, result and register channels.
// Depends on bgs_pkg, the channel interfaces in bgs_if and the core itself.
`timescale 1ns / 1ps

module testbench;
   import bgs_pkg::*;

   localparam int SAMPLE_BITS   = 12;
   localparam int MAX_RAW       = (1 << SAMPLE_BITS) - 1;
   localparam int CLK_HALF      = 10;
   localparam int RESET_CYCLES  = 12;
   localparam int SETTLE_CYCLES = 4;
   localparam int TAIL_CYCLES   = 120;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int PHASES        = 8;
   localparam int PHASE_ITEMS   = 125;

   // raw codes around the interesting part of the charge curve:
   // estimate crosses zero near 2519 and 3026, peaks above 100 near 2773
   localparam int KNEE_LO_RAW = 2400;
   localparam int KNEE_HI_RAW = 3150;
   localparam int PEAK_RAW    = 2773;

   // millivolt conversion: floor(((raw + 35) * 400 + 43) / 86)
   localparam int unsigned CONV_BIAS = 35;
   localparam int unsigned CONV_MUL  = 400;
   localparam int unsigned CONV_HALF = 43;
   localparam int unsigned CONV_DIV  = 86;
   localparam int unsigned MV_CEIL   = 32767;

   // exponential average, weight one tenth
   localparam int unsigned AVG_KEEP = 9;
   localparam int unsigned AVG_HALF = 5;
   localparam int unsigned AVG_DIV  = 10;

   // charge curve, coefficients scaled by 1e11
   localparam longint CURVE_LIN   = 64'sd204973100000;
   localparam longint CURVE_SQ    = 64'sd7847975;
   localparam longint CURVE_OFS   = 64'sd1327504000000000;
   localparam longint CURVE_SCALE = 64'sd100000000000;
   localparam longint CURVE_HALF  = 64'sd50000000000;
   localparam int     PCT_TOP     = 100;

   typedef struct packed {
      logic [MV_W-1:0]  mv;
      logic [PCT_W-1:0] pct;
      logic             charging;
      logic             dead;
   } gauge_reading_type;

   typedef enum int { RX_OPEN, RX_SPOTTY, RX_CHOKED } rx_mode_type;

   class gauge_scoreboard_type;
      logic [MV_W-1:0]   charge_thr;
      logic [MV_W-1:0]   dead_thr;
      logic [MV_W-1:0]   avg_mv;
      bit                avg_loaded;
      gauge_reading_type expected_readings[$];
      int errors, samples, readings, writes;
      int n_dead, n_charging, n_both, n_floor, n_ceiling;

      function new();
         charge_thr = CHG_THR_RST;
         dead_thr   = DEAD_THR_RST;
         avg_mv     = '0;
         avg_loaded = 0;
      endfunction

      function int pending();
         return expected_readings.size();
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [MV_W-1:0] value);
         writes++;
         case (idx)
            CSR_CHG_THR:  charge_thr = value;
            CSR_DEAD_THR: dead_thr = value;
            default: ;  // unmapped index, dropped
         endcase
      endfunction

      function logic [MV_W-1:0] to_millivolts(logic [SAMPLE_BITS-1:0] raw);
         int unsigned mv;
         mv = ((raw + CONV_BIAS) * CONV_MUL + CONV_HALF) / CONV_DIV;
         return (mv > MV_CEIL) ? MV_CEIL[MV_W-1:0] : mv[MV_W-1:0];
      endfunction

      // quadratic state of charge, rounded half away from zero, clamped 0..100
      function logic [PCT_W-1:0] curve_percent(logic [MV_W-1:0] v);
         longint x, p, r;
         x = longint'(v);
         p = CURVE_LIN * x - CURVE_SQ * x * x - CURVE_OFS;
         if (p <= 0) begin
            n_floor++;
            return '0;
         end
         r = (p + CURVE_HALF) / CURVE_SCALE;
         if (r > PCT_TOP) begin
            n_ceiling++;
            return PCT_TOP[PCT_W-1:0];
         end
         return r[PCT_W-1:0];
      endfunction

      function void note_sample(logic [SAMPLE_BITS-1:0] raw);
         gauge_reading_type rd;
         int unsigned       mv, sum;
         samples++;
         mv = to_millivolts(raw);
         if (avg_loaded) begin
            sum = AVG_KEEP * avg_mv + mv + AVG_HALF;
            sum = sum / AVG_DIV;
            avg_mv = sum[MV_W-1:0];
         end else begin
            avg_mv = mv[MV_W-1:0];  // first sample loads the average
         end
         avg_loaded = 1;
         rd.mv       = avg_mv;
         rd.charging = avg_mv > charge_thr;
         rd.dead     = avg_mv < dead_thr;
         // dead overrides charging when both hold
         if (rd.dead) rd.pct = '0;
         else if (rd.charging) rd.pct = PCT_TOP[PCT_W-1:0];
         else rd.pct = curve_percent(avg_mv);
         if (rd.dead && rd.charging) n_both++;
         else if (rd.dead) n_dead++;
         else if (rd.charging) n_charging++;
         expected_readings.push_back(rd);
      endfunction

      function void field_check(string name, int exp_v, int act_v);
         if (exp_v != act_v) begin
            errors++;
            $display("%0t: reading %0d %s mismatch, expected %0d actual %0d",
                     $time, readings, name, exp_v, act_v);
         end
      endfunction

      function void check_result(gauge_reading_type act);
         gauge_reading_type exp_rd;
         if (expected_readings.size() == 0) begin
            errors++;
            $display("%0t: unexpected reading, expected none",
                     $time);
            $display("   actual mv=%0d pct=%0d chg=%0d dead=%0d",
                     act.mv, act.pct, act.charging, act.dead);
            return;
         end
         exp_rd = expected_readings.pop_front();
         field_check("smoothed_mv", int'(exp_rd.mv), int'(act.mv));
         field_check("charge_percent", int'(exp_rd.pct), int'(act.pct));
         field_check("charging", int'(exp_rd.charging), int'(act.charging));
         field_check("dead", int'(exp_rd.dead), int'(act.dead));
         readings++;
      endfunction
   endclass

   logic clock;
   logic reset;

   bgs_req_if #(.SAMPLE_BITS(SAMPLE_BITS)) req_bus();
   bgs_rsp_if rsp_bus();
   bgs_csr_if csr_bus();

   battery_gauge_smoother_core #(.SAMPLE_BITS(SAMPLE_BITS)) DUT (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   gauge_scoreboard_type gauge = new();

   int          cycles;
   int          burst_left;
   rx_mode_type rx_mode;
   int          rx_mode_left;
   int          rx_hold;

   initial begin
      clock = 0;
      forever #CLK_HALF clock = ~clock;
   end

   // Watchdog: a hung handshake ends the run here.
   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("%0t: timeout after %0d cycles, %0d readings outstanding",
                  $time, cycles, gauge.pending());
         $display("testbench: done, errors");
         $finish;
      end
   end

   // All three channels are observed at the rising edge. Every DUT output is a
   // register, a decode of registers or a constant, so the values seen here are
   // the ones that held before the edge. Results are checked before samples are
   // noted; a sample can never produce its reading at the edge that accepts it.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_bus.valid && rsp_bus.ready)
            gauge.check_result('{rsp_bus.smoothed_mv, rsp_bus.charge_percent,
                                 rsp_bus.charging, rsp_bus.dead});
         if (req_bus.valid && req_bus.ready)
            gauge.note_sample(req_bus.raw_sample);
         if (csr_bus.valid && csr_bus.ready)
            gauge.write_reg(csr_bus.index, csr_bus.data);
      end
   end

   // Receiver back-pressure. Modes change at random: fully open, randomly
   // spotty, or long stalls broken by single ready cycles.
   always @(negedge clock) begin
      if (rx_mode_left == 0) begin
         rx_mode      = rx_mode_type'($urandom_range(RX_OPEN, RX_CHOKED));
         rx_mode_left = $urandom_range(50, 400);
      end else begin
         rx_mode_left--;
      end
      case (rx_mode)
         RX_OPEN:   rsp_bus.ready = 1'b1;
         RX_SPOTTY: rsp_bus.ready = ($urandom_range(0, 3) != 0);
         default: begin
            if (rx_hold > 0) begin
               rsp_bus.ready = 1'b0;
               rx_hold--;
            end else begin
               rsp_bus.ready = 1'b1;
               rx_hold = $urandom_range(1, 10);
            end
         end
      endcase
   end

   // Present one sample and hold it until accepted. Valid stays high into the
   // next call, so back-to-back samples keep it asserted; a burst ends with a
   // random gap of idle cycles.
   task automatic send_sample(input logic [SAMPLE_BITS-1:0] raw);
      @(negedge clock);
      req_bus.valid      = 1'b1;
      req_bus.raw_sample = raw;
      do @(posedge clock); while (!req_bus.ready);
      if (burst_left == 0) begin
         repeat ($urandom_range(1, 12)) begin
            @(negedge clock);
            req_bus.valid = 1'b0;
         end
         burst_left = $urandom_range(0, 30);
      end else begin
         burst_left--;
      end
   endtask

   // Drop valid, then wait for every outstanding reading. One sample always
   // gives one reading, so an empty queue means the core is idle again.
   task automatic drain_readings();
      @(negedge clock);
      req_bus.valid = 1'b0;
      while (gauge.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [MV_W-1:0] value);
      @(negedge clock);
      csr_bus.valid = 1'b1;
      csr_bus.index = idx;
      csr_bus.data  = value;
      do @(posedge clock); while (!csr_bus.ready);
      @(negedge clock);
      csr_bus.valid = 1'b0;
   endtask

   task automatic write_unmapped();
      write_reg(CSR_IDX_W'($urandom_range(CSR_DEAD_THR + 1, (1 << CSR_IDX_W) - 1)),
                MV_W'($urandom_range(0, MV_CEIL)));
   endtask

   // Random traffic. Most of it is runs that hover around a target level so
   // the average actually settles there (often near the curve's knee);
   // the rest is scattered noise and short runs of full-scale extremes.
   task automatic random_run(input int count);
      int sent, kind, len, target, spread, raw;
      sent = 0;
      while (sent < count) begin
         kind = $urandom_range(0, 9);
         if (kind == 0) begin
            send_sample(SAMPLE_BITS'($urandom_range(0, MAX_RAW)));
            sent++;
         end else if (kind == 1) begin
            len = $urandom_range(1, 8);
            repeat (len) send_sample(SAMPLE_BITS'($urandom_range(0, 1) ? MAX_RAW : 0));
            sent += len;
         end else begin
            target = $urandom_range(0, 1) ? $urandom_range(KNEE_LO_RAW, KNEE_HI_RAW)
                                          : $urandom_range(0, MAX_RAW);
            spread = $urandom_range(0, 60);
            len    = $urandom_range(10, 40);
            repeat (len) begin
               raw = target + int'($urandom_range(0, 2 * spread)) - spread;
               if (raw < 0) raw = 0;
               if (raw > MAX_RAW) raw = MAX_RAW;
               send_sample(SAMPLE_BITS'(raw));
            end
            sent += len;
         end
      end
   endtask

   initial begin
      logic [MV_W-1:0] chg_thr, dead_thr;

      reset              = 1'b1;
      req_bus.valid      = 1'b0;
      req_bus.raw_sample = '0;
      rsp_bus.ready      = 1'b0;
      csr_bus.valid      = 1'b0;
      csr_bus.index      = CSR_CHG_THR;
      csr_bus.data       = '0;
      burst_left         = 0;
      rx_mode            = RX_OPEN;
      rx_mode_left       = 0;
      rx_hold            = 0;

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: first sample after reset loads the average at full scale
      // (charging, forced full), then zeros pull it down, still above the charging threshold.
      send_sample(SAMPLE_BITS'(MAX_RAW));
      repeat (3) send_sample('0);
      drain_readings();

      // Thresholds out of the way so the raw curve shows: the rising average goes
      // above 100, then negative past the upper root, and comes back toward the peak.
      write_reg(CSR_CHG_THR, MV_MAX);
      write_reg(CSR_DEAD_THR, '0);
      send_sample('0);
      repeat (4) send_sample(SAMPLE_BITS'(MAX_RAW));
      repeat (6) send_sample(SAMPLE_BITS'(PEAK_RAW));
      send_sample(12'hAAA);
      send_sample(12'h555);
      drain_readings();

      // Overlapping thresholds: both flags set, dead wins.
      write_reg(CSR_CHG_THR, '0);
      write_reg(CSR_DEAD_THR, MV_MAX);
      write_unmapped();
      repeat (2) send_sample(SAMPLE_BITS'($urandom_range(0, MAX_RAW)));
      drain_readings();

      for (int ph = 0; ph < PHASES; ph++) begin
         case (ph)
            0: begin chg_thr = CHG_THR_RST; dead_thr = DEAD_THR_RST; end
            1: begin chg_thr = MV_MAX;      dead_thr = '0;           end
            2: begin chg_thr = '0;          dead_thr = MV_MAX;       end
            3: begin chg_thr = '0;          dead_thr = '0;           end
            4: begin chg_thr = MV_MAX;      dead_thr = MV_MAX;       end
            default: begin
               // mostly near the knee, so the forced and curve regions mix
               chg_thr  = MV_W'($urandom_range(0, 3) ? $urandom_range(11000, 15000)
                                                     : $urandom_range(0, MV_CEIL));
               dead_thr = MV_W'($urandom_range(0, 3) ? $urandom_range(10000, 14000)
                                                     : $urandom_range(0, MV_CEIL));
            end
         endcase
         write_reg(CSR_CHG_THR, chg_thr);
         write_reg(CSR_DEAD_THR, dead_thr);
         if ($urandom_range(0, 1)) write_unmapped();
         random_run(PHASE_ITEMS);
         drain_readings();
      end

      repeat (TAIL_CYCLES) @(posedge clock);

      $display("%0d samples, %0d readings checked, %0d register writes, %0d cycles",
               gauge.samples, gauge.readings, gauge.writes, cycles);
      $display("dead %0d, charging %0d, both %0d, curve floored %0d, curve capped %0d",
               gauge.n_dead, gauge.n_charging, gauge.n_both, gauge.n_floor, gauge.n_ceiling);
      if (gauge.errors == 0 && gauge.pending() == 0) begin
         $display("testbench: done, clean");
      end else begin
         $display("testbench: done, errors");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
hdl/bgs_pkg.sv
hdl/bgs_if.sv
hdl/bgs_cdiv.sv
hdl/bgs_smul.sv
hdl/battery_gauge_smoother_core.sv
test/testbench.sv
